/* rtl/core/sbrp_pkg.sv */
`default_nettype none

package sbrp_pkg;

  // default packet size limit in bytes
  localparam int unsigned MaxPacketBytesDef = 2048;

  localparam logic [31:0] MagicCookie     = 32'h2112A442;
  localparam logic [15:0] TypeBindingResp = 16'h0101;
  localparam logic [15:0] AttrXorMapped   = 16'h0020;
  localparam logic [7:0]  FamilyIpv4      = 8'h01;

  localparam int unsigned HeaderBytes = 20;
  // width of attribute offsets and end positions
  localparam int unsigned OffsW = 18;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ATTR_HEAD,
    PH_SKIP,
    PH_FOUND,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_PARSE,
    ST_NOT_FOUND
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
    logic [15:0] port;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/sbrp_walker.sv */
`default_nettype none

module sbrp_walker #(
  parameter int unsigned MaxPacketBytes = sbrp_pkg::MaxPacketBytesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire sbrp_pkg::item_t  item_i,
  output sbrp_pkg::result_t     result_o
);
  import sbrp_pkg::*;

  localparam int unsigned PosW = $clog2(MaxPacketBytes + 2);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [31:0]      hdr_q, hdr_d;
  logic [15:0]      msg_len_q, msg_len_d;
  logic             hdr_bad_q, hdr_bad_d;
  phase_e           phase_q, phase_d;
  logic [15:0]      attr_type_q, attr_type_d;
  logic [15:0]      attr_len_q, attr_len_d;
  logic [OffsW-1:0] start_q, start_d;
  status_e          outcome_q, outcome_d;
  logic [OffsW-1:0] req_end_q, req_end_d;
  logic [15:0]      port_q, port_d;
  logic [31:0]      addr_q, addr_d;

  logic [OffsW-1:0] p_w;
  logic [OffsW-1:0] len_w;
  logic [OffsW-1:0] k;
  logic [OffsW-1:0] msg_end;
  logic [OffsW-1:0] new_start;
  logic [OffsW-1:0] enter_start;
  logic [1:0]       pad;
  logic             take;
  logic             enter_req;
  status_e          status;

  always_comb begin
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    msg_len_d   = msg_len_q;
    hdr_bad_d   = hdr_bad_q;
    phase_d     = phase_q;
    attr_type_d = attr_type_q;
    attr_len_d  = attr_len_q;
    start_d     = start_q;
    outcome_d   = outcome_q;
    req_end_d   = req_end_q;
    port_d      = port_q;
    addr_d      = addr_q;
    enter_req   = 1'b0;
    enter_start = start_q;
    new_start   = '0;
    pad         = '0;

    p_w  = OffsW'(pos_q);
    take = p_w < OffsW'(MaxPacketBytes);
    k    = p_w - start_q;

    if (take) begin
      pos_d = pos_q + PosW'(1);
      case (phase_q)
        PH_HEADER: begin
          hdr_d = {hdr_q[23:0], item_i.data};
          if (p_w == OffsW'(1) && hdr_d[15:0] != TypeBindingResp) hdr_bad_d = 1'b1;
          if (p_w == OffsW'(3)) msg_len_d = hdr_d[15:0];
          if (p_w == OffsW'(7) && hdr_d != MagicCookie) hdr_bad_d = 1'b1;
          if (p_w == OffsW'(HeaderBytes - 1)) begin
            enter_req   = 1'b1;
            enter_start = OffsW'(HeaderBytes);
          end
        end
        PH_ATTR_HEAD: begin
          if (!k[1]) begin
            attr_type_d = {attr_type_q[7:0], item_i.data};
          end else begin
            attr_len_d = {attr_len_q[7:0], item_i.data};
          end
          if (k[1:0] == 2'd3) begin
            req_end_d = start_q + OffsW'(4) + OffsW'(attr_len_d);
            if (attr_type_q == AttrXorMapped && attr_len_d >= 16'd8) begin
              start_d   = start_q + OffsW'(4);
              outcome_d = ST_OK;
              phase_d   = PH_FOUND;
            end else begin
              pad       = 2'd0 - attr_len_d[1:0];
              new_start = req_end_d + OffsW'(pad);
              start_d   = new_start;
              if (new_start <= p_w + OffsW'(1)) begin
                enter_req   = 1'b1;
                enter_start = new_start;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (p_w + OffsW'(1) >= start_q) begin
            enter_req   = 1'b1;
            enter_start = start_q;
          end
        end
        PH_FOUND: begin
          if (k == OffsW'(1) && item_i.data != FamilyIpv4) begin
            outcome_d = ST_PARSE;
          end else if (k == OffsW'(2) || k == OffsW'(3)) begin
            port_d = {port_q[7:0], item_i.data};
          end else if (k >= OffsW'(4) && k < OffsW'(8)) begin
            addr_d = {addr_q[23:0], item_i.data};
          end
        end
        default: begin
        end
      endcase
    end else begin
      pos_d = PosW'(MaxPacketBytes + 1);
    end

    // walk ends once an attribute would start at or past the message end
    msg_end = OffsW'(HeaderBytes) + OffsW'(msg_len_d);
    if (enter_req) begin
      start_d = enter_start;
      if (enter_start >= msg_end) begin
        phase_d   = PH_DONE;
        outcome_d = ST_NOT_FOUND;
      end else begin
        phase_d = PH_ATTR_HEAD;
      end
    end

    len_w = OffsW'(pos_d);
    if (len_w > OffsW'(MaxPacketBytes)) begin
      status = ST_PARSE;
    end else if (len_w < OffsW'(HeaderBytes)) begin
      status = ST_SHORT;
    end else if (hdr_bad_d || msg_end > len_w) begin
      status = ST_PARSE;
    end else begin
      case (phase_d)
        PH_SKIP:  status = (len_w < req_end_d) ? ST_PARSE : ST_NOT_FOUND;
        PH_FOUND: status = (len_w < req_end_d) ? ST_PARSE : outcome_d;
        PH_DONE:  status = outcome_d;
        default:  status = ST_NOT_FOUND;
      endcase
    end

    result_o.status = status;
    if (status == ST_OK) begin
      result_o.address = addr_d ^ MagicCookie;
      result_o.port    = port_d ^ MagicCookie[31:16];
    end else begin
      result_o.address = '0;
      result_o.port    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_q       <= '0;
      msg_len_q   <= '0;
      hdr_bad_q   <= 1'b0;
      phase_q     <= PH_HEADER;
      attr_type_q <= '0;
      attr_len_q  <= '0;
      start_q     <= OffsW'(HeaderBytes);
      outcome_q   <= ST_NOT_FOUND;
      req_end_q   <= '0;
      port_q      <= '0;
      addr_q      <= '0;
    end else if (step_i && item_i.last) begin
      // packet done, back to the reset state for the next one
      pos_q       <= '0;
      hdr_q       <= '0;
      msg_len_q   <= '0;
      hdr_bad_q   <= 1'b0;
      phase_q     <= PH_HEADER;
      attr_type_q <= '0;
      attr_len_q  <= '0;
      start_q     <= OffsW'(HeaderBytes);
      outcome_q   <= ST_NOT_FOUND;
      req_end_q   <= '0;
      port_q      <= '0;
      addr_q      <= '0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      hdr_q       <= hdr_d;
      msg_len_q   <= msg_len_d;
      hdr_bad_q   <= hdr_bad_d;
      phase_q     <= phase_d;
      attr_type_q <= attr_type_d;
      attr_len_q  <= attr_len_d;
      start_q     <= start_d;
      outcome_q   <= outcome_d;
      req_end_q   <= req_end_d;
      port_q      <= port_d;
      addr_q      <= addr_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last |=> pos_q == '0 && phase_q == PH_HEADER)
    else $error("walker did not restart after last byte");

  a_header_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q > PosW'(HeaderBytes) |-> phase_q != PH_HEADER)
    else $error("still in header phase past the header");

  a_ok_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outcome_q == ST_OK |-> phase_q == PH_FOUND)
    else $error("ok outcome outside found phase");

endmodule

`default_nettype wire

/* rtl/core/sbrp_out_reg.sv */
`default_nettype none

module sbrp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire sbrp_pkg::result_t result_i,
  input  wire logic              out_stall_i,
  output logic                   blocked_o,
  output logic                   out_valid_o,
  output sbrp_pkg::result_t      result_o
);
  import sbrp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign blocked_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !out_stall_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= result_i;
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

/* rtl/core/stun_binding_response_parser_unit.sv */
// stun binding response parser: pulls the ipv4 xor-mapped-address out of a
// received stun packet that arrives one byte per request
//
// input channel: in_valid_i / in_stall_o with packet_byte_i and last_byte_i;
// last_byte_i marks the final byte of a packet
// output channel: out_valid_o / out_stall_i with status_o, mapped_address_o
// and mapped_port_o; exactly one result request per packet, on its last byte
//
// out_valid_o rises once a last byte has passed the input register and then the
// result register; it is later only while an earlier result still sits stalled
// throughput: one byte per cycle while no last byte waits behind a stalled result,
// set by the header/attribute walker between the input register and the result register
//
// reset clears the input and result valids and puts the walker back to the
// start of a packet; the walker also restarts by itself after each last byte
// a stalled result only holds back a last byte waiting behind it; ordinary
// bytes keep flowing while the result waits to be taken
`default_nettype none

module stun_binding_response_parser_unit #(
  parameter int unsigned MaxPacketBytes = sbrp_pkg::MaxPacketBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  packet_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      mapped_address_o,
  output logic [15:0]      mapped_port_o
);
  import sbrp_pkg::*;

  // input register
  logic    in_valid_q, in_valid_d;
  item_t   item_q;
  logic    accept;
  logic    step;
  logic    out_blocked;
  result_t walk_res;
  result_t out_res;

  // a last byte must wait until the result slot is free or draining
  assign step       = in_valid_q && !(item_q.last && out_blocked);
  assign in_stall_o = in_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (step) in_valid_d = 1'b0;
    if (accept) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data <= packet_byte_i;
      item_q.last <= last_byte_i;
    end
  end

  // header checks and attribute walk, one byte per step
  sbrp_walker #(
    .MaxPacketBytes(MaxPacketBytes)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .result_o(walk_res)
  );

  // result register, loaded on the last byte of each packet
  sbrp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && item_q.last),
    .result_i   (walk_res),
    .out_stall_i(out_stall_i),
    .blocked_o  (out_blocked),
    .out_valid_o(out_valid_o),
    .result_o   (out_res)
  );

  assign status_o         = out_res.status;
  assign mapped_address_o = out_res.address;
  assign mapped_port_o    = out_res.port;

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_plain_byte_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !item_q.last |-> !in_stall_o)
    else $error("non-last byte held back");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && item_q.last |=> out_valid_o)
    else $error("last byte produced no result");

endmodule

`default_nettype wire
